[rtl/jpeg_coefficient_quantizer_unit_defines.svh]
// Assertion macros for the coefficient quantizer.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef JPEG_COEFFICIENT_QUANTIZER_UNIT_DEFINES_SVH
`define JPEG_COEFFICIENT_QUANTIZER_UNIT_DEFINES_SVH

// The consequent may start with a delay operator.
`define JCQ_ASSERT_THEN(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

`define JCQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/jcq_pkg.sv]
`default_nettype none

package jcq_pkg;

	localparam int COEF_W  = 16;
	localparam int POS_W   = 6;
	localparam int SHIFT_W = 4;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUANT = 1'b1
	} op_t;

	typedef struct packed {
		logic [COEF_W-1:0]  recip;
		logic [COEF_W-1:0]  corr;
		logic [SHIFT_W-1:0] shift;
	} entry_t;

	typedef struct packed {
		logic              valid;
		logic              sign;
		logic [COEF_W-1:0] mag;
		logic [POS_W-1:0]  pos;
	} item_t;

endpackage

`default_nettype wire

[rtl/jpeg_coefficient_quantizer_unit.sv]
// Reciprocal quantizer for signed 16-bit DCT coefficients. One item is taken in every
// clock cycle and busy is always low. A quantize item shows its result on quantized and
// out_position with done high for one cycle, after passing its registered stages: one
// stage for the table read and magnitude, one for the correction add, one for the
// 16x16 reciprocal multiply and one for the shift and sign restore. A load item writes
// its table entry at its transfer and gives no result; a quantize item in the very next
// cycle already sees it. The result cannot be held off, so a result not captured in its
// cycle is gone. The table has no reset: quantize only positions that were loaded.
`default_nettype none

`include "jpeg_coefficient_quantizer_unit_defines.svh"

module jpeg_coefficient_quantizer_unit #(
	parameter int BLOCK_POSITIONS = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                operation,
	input  wire logic        [jcq_pkg::POS_W-1:0]    position,
	input  wire logic signed [jcq_pkg::COEF_W-1:0]   coefficient,
	input  wire logic        [jcq_pkg::COEF_W-1:0]   reciprocal,
	input  wire logic        [jcq_pkg::COEF_W-1:0]   correction,
	input  wire logic        [jcq_pkg::SHIFT_W-1:0]  shift_amount,
	output logic                                     done,
	output logic signed [jcq_pkg::COEF_W-1:0]        quantized,
	output logic        [jcq_pkg::POS_W-1:0]         out_position
);

	localparam int IDX_W     = $clog2(BLOCK_POSITIONS);
	localparam int MOD_STEPS = (2**jcq_pkg::POS_W) / BLOCK_POSITIONS;

	logic                       accept;
	logic                       is_quant;
	logic [jcq_pkg::POS_W-1:0]  rem;
	logic [IDX_W-1:0]           idx;
	logic [jcq_pkg::COEF_W-1:0] coef_u;
	jcq_pkg::entry_t            wentry;
	jcq_pkg::entry_t            entry_s1;
	jcq_pkg::item_t             item_s1;

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign is_quant = (operation == jcq_pkg::OP_QUANT);
	assign coef_u   = coefficient;

	// Position folded into the table: 2**POS_W / BLOCK_POSITIONS conditional subtractions
	// suffice, since the position never reaches 2**POS_W.
	always_comb begin
		rem = position;
		for (int i = 0; i < MOD_STEPS; i++) begin
			if (int'(rem) >= BLOCK_POSITIONS) begin
				rem = rem - jcq_pkg::POS_W'(BLOCK_POSITIONS);
			end
		end
		idx = IDX_W'(rem);
	end

	assign wentry.recip = reciprocal;
	assign wentry.corr  = correction;
	assign wentry.shift = shift_amount;

	jcq_table #(
		.DEPTH(BLOCK_POSITIONS)
	) u_table (
		.clk   (clk),
		.we    (accept && !is_quant),
		.re    (accept && is_quant),
		.addr  (idx),
		.wdata (wentry),
		.rdata (entry_s1)
	);

	// The most negative coefficient wraps to the magnitude 32768.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else begin
			item_s1.valid <= accept && is_quant;
			item_s1.sign  <= coefficient[jcq_pkg::COEF_W-1];
			item_s1.mag   <= coefficient[jcq_pkg::COEF_W-1] ? (~coef_u + 1'b1) : coef_u;
			item_s1.pos   <= position;
		end
	end

	jcq_arith u_arith (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_s1      (item_s1),
		.entry_s1     (entry_s1),
		.done         (done),
		.quantized    (quantized),
		.out_position (out_position)
	);

	`JCQ_ASSERT_THEN(a_quant_done, accept && is_quant, ##4 done, "quantize transfer gave no result")
	`JCQ_ASSERT_THEN(a_load_silent, accept && !is_quant, ##4 !done, "load transfer gave a result")
	`JCQ_ASSERT_NEXT(a_pos_follows, item_s1.valid, ##2 (out_position == $past(item_s1.pos, 3)), "position lost in pipeline")

endmodule

`default_nettype wire

[rtl/jcq_table.sv]
`default_nettype none

module jcq_table #(
	parameter int DEPTH = 64
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic                      re,
	input  wire logic [$clog2(DEPTH)-1:0]  addr,
	input  wire jcq_pkg::entry_t           wdata,
	output jcq_pkg::entry_t                rdata
);

	jcq_pkg::entry_t mem [DEPTH];

	// A load and a quantize never share an edge, so one port serves both.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

[rtl/jcq_arith.sv]
`default_nettype none

module jcq_arith (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire jcq_pkg::item_t                    item_s1,
	input  wire jcq_pkg::entry_t                   entry_s1,
	output logic                                   done,
	output logic signed [jcq_pkg::COEF_W-1:0]      quantized,
	output logic        [jcq_pkg::POS_W-1:0]       out_position
);

	localparam int W = jcq_pkg::COEF_W;

	logic                        valid_s2;
	logic                        sign_s2;
	logic [jcq_pkg::POS_W-1:0]   pos_s2;
	logic [W-1:0]                sum_s2;
	logic [W-1:0]                recip_s2;
	logic [jcq_pkg::SHIFT_W-1:0] shift_s2;

	logic                        valid_s3;
	logic                        sign_s3;
	logic [jcq_pkg::POS_W-1:0]   pos_s3;
	logic [W-1:0]                hi_s3;
	logic [jcq_pkg::SHIFT_W-1:0] shift_s3;

	logic                        valid_s4;
	logic [jcq_pkg::POS_W-1:0]   pos_s4;
	logic [W-1:0]                quant_s4;

	logic [2*W-1:0] prod;
	logic [W-1:0]   shifted;
	logic [W-1:0]   sign_mask;

	assign prod      = sum_s2 * recip_s2;
	assign shifted   = hi_s3 >> shift_s3;
	assign sign_mask = {W{sign_s3}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s2 <= item_s1.valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		// The correction is added modulo 2^16, as the table entry defines it.
		sign_s2  <= item_s1.sign;
		pos_s2   <= item_s1.pos;
		sum_s2   <= item_s1.mag + entry_s1.corr;
		recip_s2 <= entry_s1.recip;
		shift_s2 <= entry_s1.shift;

		sign_s3  <= sign_s2;
		pos_s3   <= pos_s2;
		hi_s3    <= prod[2*W-1:W];
		shift_s3 <= shift_s2;

		pos_s4   <= pos_s3;
		quant_s4 <= (shifted ^ sign_mask) - sign_mask;
	end

	assign done         = valid_s4;
	assign quantized    = $signed(quant_s4);
	assign out_position = pos_s4;

endmodule

`default_nettype wire
